[src/pyob_pkg.sv]
// ----------------------------------------------------------------------------
// pyob_pkg
// Shared types and constants for the packed 4:2:2 overlay blender.
// ----------------------------------------------------------------------------
package pyob_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LANES        = 4;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam logic [8:0]  GLYPH_CHROMA_THRESHOLD = 9'd150;

    localparam logic [7:0]  TEXT_LUMA_RESET = 8'd255;
    localparam logic [7:0]  TEXT_CB_RESET   = 8'd128;
    localparam logic [7:0]  TEXT_CR_RESET   = 8'd128;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PIXEL_ORDER = 3'd0,
        CFG_BLEND_MODE  = 3'd1,
        CFG_TEXT_LUMA   = 3'd2,
        CFG_TEXT_CB     = 3'd3,
        CFG_TEXT_CR     = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_COPY        = 2'd0,
        MODE_IMAGE       = 2'd1,
        MODE_GLYPH       = 2'd2,
        MODE_GLYPH_COLOR = 2'd3
    } blend_mode_t;

    typedef enum logic {
        ORDER_YUY2 = 1'b0,
        ORDER_UYVY = 1'b1
    } pixel_order_t;

    // How one output byte is formed in the last stage
    typedef enum logic [2:0] {
        OP_PASS_FRAME   = 3'd0,   // r = d
        OP_PASS_OVERLAY = 3'd1,   // r = s
        OP_ADD          = 3'd2,   // r = s + ((d*m) >> 8)
        OP_MIX          = 3'd3,   // r = (d*m + s*k) >> 8
        OP_CONST        = 3'd4    // r = k
    } lane_op_t;

    typedef struct packed {
        lane_op_t    op;
        logic [7:0]  d;
        logic [8:0]  m;
        logic [7:0]  s;
        logic [7:0]  k;
    } lane_in_t;

    typedef struct packed {
        logic load2;
        logic load3;
    } stage_en_t;

    typedef struct packed {
        logic [7:0] frame_byte0;
        logic [7:0] frame_byte1;
        logic [7:0] frame_byte2;
        logic [7:0] frame_byte3;
        logic [7:0] overlay_byte0;
        logic [7:0] overlay_byte1;
        logic [7:0] overlay_byte2;
        logic [7:0] overlay_byte3;
        logic [7:0] alpha_first;
        logic [7:0] alpha_second;
    } pair_t;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
    } blend_t;

endpackage

[src/pyob_lane.sv]
// ----------------------------------------------------------------------------
// pyob_lane
// One byte lane: multiply stage, then combine stage into the output byte.
// ----------------------------------------------------------------------------
module pyob_lane (
    input  logic              clk,
    input  pyob_pkg::stage_en_t en,
    input  pyob_pkg::lane_in_t  lane_in,
    output logic [7:0]        result
);
    import pyob_pkg::*;

    logic [15:0] prod_frame;
    logic [15:0] prod_text;
    logic [15:0] mix_sum;
    logic [7:0]  result_next;

    logic [15:0] p1_reg;
    logic [15:0] p2_reg;
    lane_op_t    op_reg;
    logic [7:0]  d_reg;
    logic [7:0]  s_reg;
    logic [7:0]  k_reg;
    logic [7:0]  result_reg;

    // d*m never exceeds 255*256, so 16 bits hold it
    assign prod_frame = 16'(lane_in.d) * 16'(lane_in.m);
    assign prod_text  = 16'(lane_in.s) * 16'(lane_in.k);

    always_ff @(posedge clk)
    begin
        if (en.load2)
        begin
            p1_reg <= prod_frame;
            p2_reg <= prod_text;
            op_reg <= lane_in.op;
            d_reg  <= lane_in.d;
            s_reg  <= lane_in.s;
            k_reg  <= lane_in.k;
        end
    end

    // the sum is kept to 16 bits, so a carry out of bit 15 is dropped
    assign mix_sum = p1_reg + p2_reg;

    always_comb
    begin
        case (op_reg)
            OP_PASS_FRAME:   result_next = d_reg;
            OP_PASS_OVERLAY: result_next = s_reg;
            OP_ADD:          result_next = s_reg + p1_reg[15:8];
            OP_MIX:          result_next = mix_sum[15:8];
            OP_CONST:        result_next = k_reg;
            default:         result_next = d_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.load3)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[src/packed_yuv422_overlay_blender_core.sv]
// ----------------------------------------------------------------------------
// packed_yuv422_overlay_blender_core
// Blends an overlay into one packed 4:2:2 pixel pair per word.
// ----------------------------------------------------------------------------
// Takes one pair word per clock and returns one blended word per clock while
// the output is not stalled. The path is three register stages: operand
// select, the per-byte multipliers, and the final add/select into the output
// register. Each stage holds its own valid bit and moves up as soon as the
// stage ahead is free, so bubbles collapse and a stalled output still lets
// the input run until the pipe is full. Write configuration only while no
// word is in flight.
module packed_yuv422_overlay_blender_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pair_valid,
    output logic                  pair_stall,
    input  pyob_pkg::pair_t       pair_data,
    output logic                  blend_valid,
    input  logic                  blend_stall,
    output pyob_pkg::blend_t      blend_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [pyob_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]            cfg_data
);
    import pyob_pkg::*;

    pixel_order_t pixel_order_reg;
    blend_mode_t  blend_mode_reg;
    logic [7:0]   text_luma_reg;
    logic [7:0]   text_cb_reg;
    logic [7:0]   text_cr_reg;

    logic         s1_valid_reg;
    logic         s2_valid_reg;
    logic         s3_valid_reg;
    logic         ready1;
    logic         ready2;
    logic         ready3;
    logic         load1;
    stage_en_t    lane_en;

    logic [7:0]   frame [LANES];
    logic [7:0]   overlay [LANES];
    logic [8:0]   glyph_sum;
    logic         chroma_hit;
    lane_in_t     lane_next [LANES];
    lane_in_t     lane_reg [LANES];
    logic [7:0]   lane_result [LANES];

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_order_reg <= ORDER_YUY2;
            blend_mode_reg  <= MODE_COPY;
            text_luma_reg   <= TEXT_LUMA_RESET;
            text_cb_reg     <= TEXT_CB_RESET;
            text_cr_reg     <= TEXT_CR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PIXEL_ORDER: pixel_order_reg <= pixel_order_t'(cfg_data[0]);
                CFG_BLEND_MODE:  blend_mode_reg  <= blend_mode_t'(cfg_data[1:0]);
                CFG_TEXT_LUMA:   text_luma_reg   <= cfg_data;
                CFG_TEXT_CB:     text_cb_reg     <= cfg_data;
                CFG_TEXT_CR:     text_cr_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    assign ready3     = !s3_valid_reg || !blend_stall;
    assign ready2     = !s2_valid_reg || ready3;
    assign ready1     = !s1_valid_reg || ready2;
    assign pair_stall = !ready1;
    assign load1      = pair_valid && ready1;
    assign lane_en.load2 = s1_valid_reg && ready2;
    assign lane_en.load3 = s2_valid_reg && ready3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= pair_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ---------------- operand select ----------------
    assign frame[0]   = pair_data.frame_byte0;
    assign frame[1]   = pair_data.frame_byte1;
    assign frame[2]   = pair_data.frame_byte2;
    assign frame[3]   = pair_data.frame_byte3;
    assign overlay[0] = pair_data.overlay_byte0;
    assign overlay[1] = pair_data.overlay_byte1;
    assign overlay[2] = pair_data.overlay_byte2;
    assign overlay[3] = pair_data.overlay_byte3;

    assign glyph_sum  = 9'(pair_data.overlay_byte0) + 9'(pair_data.overlay_byte1);
    assign chroma_hit = glyph_sum > GLYPH_CHROMA_THRESHOLD;

    always_comb
    begin
        logic [1:0] pos;
        logic       second;
        logic       is_luma;
        logic [7:0] alpha_img;
        logic [7:0] alpha_pix;
        logic [7:0] glyph;

        for (int i = 0; i < LANES; i++)
        begin
            pos       = 2'(i);
            second    = pos[1];
            // byte 2 is the only one blended with the second alpha in image mode
            alpha_img = (pos == 2'd2) ? pair_data.alpha_second : pair_data.alpha_first;
            alpha_pix = second ? pair_data.alpha_second : pair_data.alpha_first;
            glyph     = second ? pair_data.overlay_byte1 : pair_data.overlay_byte0;
            is_luma   = (pos[0] == pixel_order_reg);

            lane_next[i].op = OP_PASS_FRAME;
            lane_next[i].d  = frame[i];
            lane_next[i].m  = 9'(alpha_pix);
            lane_next[i].s  = glyph;
            lane_next[i].k  = text_luma_reg;

            case (blend_mode_reg)
                MODE_COPY:
                begin
                    lane_next[i].op = OP_PASS_OVERLAY;
                    lane_next[i].s  = overlay[i];
                end
                MODE_IMAGE:
                begin
                    lane_next[i].s  = overlay[i];
                    lane_next[i].m  = 9'(alpha_img) + 9'd1;
                    lane_next[i].op = (alpha_img == 8'd0) ? OP_PASS_OVERLAY : OP_ADD;
                end
                MODE_GLYPH:
                begin
                    if (is_luma && alpha_pix != 8'd0)
                    begin
                        lane_next[i].op = OP_ADD;
                    end
                end
                MODE_GLYPH_COLOR:
                begin
                    if (is_luma)
                    begin
                        if (alpha_pix != 8'd0)
                        begin
                            lane_next[i].op = OP_MIX;
                        end
                    end
                    else if (chroma_hit)
                    begin
                        lane_next[i].op = OP_CONST;
                        lane_next[i].k  = second ? text_cr_reg : text_cb_reg;
                    end
                end
                default:
                begin
                    lane_next[i].op = OP_PASS_FRAME;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                lane_reg[i] <= lane_next[i];
            end
        end
    end

    // ---------------- multiply and combine ----------------
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        pyob_lane u_lane (
            .clk     (clk),
            .en      (lane_en),
            .lane_in (lane_reg[g]),
            .result  (lane_result[g])
        );
    end

    assign blend_valid          = s3_valid_reg;
    assign blend_data.out_byte0 = lane_result[0];
    assign blend_data.out_byte1 = lane_result[1];
    assign blend_data.out_byte2 = lane_result[2];
    assign blend_data.out_byte3 = lane_result[3];

endmodule

[src/pyob_checker.sv]
// ----------------------------------------------------------------------------
// pyob_checker
// Port-level checks for the overlay blender, bound onto the top level.
// ----------------------------------------------------------------------------
module pyob_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pair_valid,
    input logic              pair_stall,
    input logic              blend_valid,
    input logic              blend_stall,
    input pyob_pkg::blend_t  blend_data
);
    import pyob_pkg::*;

    logic pair_take;

    assign pair_take = pair_valid && !pair_stall;

    // a stalled result word stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid && blend_stall |=> blend_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its value
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid && blend_stall |=> $stable(blend_data))
        else $error("result word changed while stalled");

    // with the output free while it moves through, an accepted word reaches the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        pair_take ##1 !blend_stall ##1 !blend_stall |=> blend_valid)
        else $error("accepted word did not reach the output");

    // with no input and a free output, the pipe drains empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!pair_take && !blend_stall) ##1 (!pair_take && !blend_stall)
            ##1 (!pair_take && !blend_stall) |=> !blend_valid)
        else $error("result word appeared without an input word");

endmodule

bind packed_yuv422_overlay_blender_core pyob_checker u_pyob_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .blend_valid (blend_valid),
    .blend_stall (blend_stall),
    .blend_data  (blend_data)
);
